// File: design/bmf_pkg.sv
// Package for the box mean filter: shared types, widths and the divider table.
// Used by box_mean_filter_2d and bmf_cell; depends on nothing.
package bmf_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_LINE_WIDTH_DEF = 1024;
	localparam int MAX_RADIUS_DEF     = 3;

	// Largest frame dimension that the row and column counters carry.
	localparam int FRAME_LIMIT = 1024;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	// A column sum covers at most 15 pixels (radius up to 7); a window at most 225.
	localparam int COLSUM_W = 12;
	localparam int WSUM_W   = 16;
	localparam int ROW_W    = 11;

	// Reciprocal of (2r+1)^2 scaled by 2^24 and rounded up, for r = 0..7.
	// Exact truncated quotient for every window sum below 2^16.
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = 25;
	localparam logic [RECIP_W-1:0] RECIP [8] = '{
		25'd16777216, 25'd1864136, 25'd671089, 25'd342393,
		25'd207127,   25'd138655,  25'd99274,  25'd74566
	};

	// One column sum of the sliding window and the input row that produced it.
	typedef struct packed {
		logic [COLSUM_W-1:0] colsum;
		logic [ROW_W-1:0]    row;
	} cell_t;

endpackage

// File: design/bmf_line_bank.sv
// One line buffer bank: a single stored row of pixels, one read and at most one write per item.
// Uses no package; instantiated once per row slot by box_mean_filter_2d.
module bmf_line_bank #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [7:0]               wdata,
	output logic [7:0]               rdata
);

	logic [7:0] mem [DEPTH];

	// Write the incoming pixel into its column.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// Registered read of the same column of this row.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// File: design/bmf_cell.sv
// One cell of the window chain: holds one column sum and passes it to its neighbor.
// Depends on bmf_pkg for cell_t.
module bmf_cell (
	input  logic                           clk,
	input  logic                           shift,
	input  logic                           enable,
	input  logic [bmf_pkg::ROW_W-1:0]      want_row,
	input  bmf_pkg::cell_t                 d,
	output bmf_pkg::cell_t                 q,
	output logic [bmf_pkg::COLSUM_W-1:0]   contrib
);

	bmf_pkg::cell_t data_q;

	// Take the neighbor's column whenever a new item enters the chain.
	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	assign q = data_q;

	// The column counts only if it lies inside the window and its row is the output row plus r.
	assign contrib = (enable && data_q.row == want_row) ? data_q.colsum : '0;

endmodule

// File: design/box_mean_filter_2d.sv
// Top level of the streaming 2-D box mean filter with zero padding.
// Depends on bmf_pkg, bmf_line_bank and bmf_cell.
//
// The block takes one pixel per clock when the output side is not stalled; the item
// that releases a result passes the stage 1, 2 and 3 registers and the output register;
// the rate is set by the single read port of each line bank, read once per item. Line
// banks hold 2*MAX_RADIUS+2 rows and are not cleared after reset: rows above the frame
// are masked instead.
// Each frame needs window_radius*frame_width+window_radius flush items after its
// last pixel; a write to one of the three configuration registers restarts the frame.
module box_mean_filter_2d #(
	parameter int MAX_LINE_WIDTH = bmf_pkg::MAX_LINE_WIDTH_DEF,
	parameter int MAX_RADIUS     = bmf_pkg::MAX_RADIUS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // pixel_in
	input  logic        s_axis_tuser,  // flush
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // mean_value, out_row, out_col, zero fill
	output logic        m_axis_tlast   // frame_last
);

	localparam int SLOTS = 2 * MAX_RADIUS + 2;
	localparam int SW    = $clog2(SLOTS);
	localparam int AW    = $clog2(MAX_LINE_WIDTH);
	localparam int CELLS = 2 * MAX_RADIUS + 1;
	localparam int WLIM  = (MAX_LINE_WIDTH < bmf_pkg::FRAME_LIMIT) ?
		MAX_LINE_WIDTH : bmf_pkg::FRAME_LIMIT;
	localparam int RW    = $clog2(MAX_RADIUS + 1);
	localparam int NW    = 21;

	// Configuration registers.
	logic [1:0]  radius_q;
	logic [10:0] width_q;
	logic [10:0] height_q;

	// Effective, saturated configuration.
	logic [RW-1:0] r_eff;
	logic [10:0]   w_eff;
	logic [10:0]   h_eff;
	logic [NW-1:0] lag;

	// Input and output position counters.
	logic [9:0]    in_col_q;
	logic [10:0]   in_row_q;
	logic [SW-1:0] in_slot_q;
	logic [NW-1:0] n_q;
	logic [9:0]    out_row_q;
	logic [9:0]    out_col_q;

	logic adv;
	logic accept;
	logic emit;
	logic last;
	logic cfg_hit;
	logic [7:0] pix;

	// Pipeline stage 1: after the line bank read.
	logic          v_s1, emit_s1, last_s1;
	logic [7:0]    pix_s1;
	logic [SW-1:0] slot_s1;
	logic [10:0]   row_s1;
	logic [9:0]    orow_s1, ocol_s1;
	logic [7:0]    rd [SLOTS];
	logic [bmf_pkg::COLSUM_W-1:0] colsum;

	// Pipeline stage 2: window in the cell chain.
	logic        v_s2, emit_s2, last_s2;
	logic [9:0]  orow_s2, ocol_s2;
	bmf_pkg::cell_t chain [CELLS+1];
	logic [bmf_pkg::COLSUM_W-1:0] contrib [CELLS];
	logic [bmf_pkg::ROW_W-1:0] want_row;
	logic [bmf_pkg::WSUM_W-1:0] wsum;

	// Pipeline stage 3: window sum.
	logic        v_s3, emit_s3, last_s3;
	logic [9:0]  orow_s3, ocol_s3;
	logic [bmf_pkg::WSUM_W-1:0] wsum_s3;
	logic [bmf_pkg::WSUM_W+bmf_pkg::RECIP_W-1:0] prod;

	// Output register.
	logic       out_valid_q;
	logic [7:0] mean_q;
	logic [9:0] orow_q, ocol_q;
	logic       last_q;

	// Saturate the configuration to what the hardware supports.
	always_comb begin
		r_eff = ({1'b0, radius_q} > 3'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_q);
		if (width_q == 11'd0) begin
			w_eff = 11'd1;
		end else if (width_q > 11'(WLIM)) begin
			w_eff = 11'(WLIM);
		end else begin
			w_eff = width_q;
		end
		if (height_q == 11'd0) begin
			h_eff = 11'd1;
		end else if (height_q > 11'(bmf_pkg::FRAME_LIMIT)) begin
			h_eff = 11'(bmf_pkg::FRAME_LIMIT);
		end else begin
			h_eff = height_q;
		end
		lag = NW'(r_eff) * NW'(w_eff) + NW'(r_eff);
	end

	// Handshake: the whole pipe moves when the output register can take a result.
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;
	assign cfg_hit       = cfg_we && (cfg_index == bmf_pkg::REG_RADIUS ||
		cfg_index == bmf_pkg::REG_WIDTH || cfg_index == bmf_pkg::REG_HEIGHT);

	// Item decode: zero pixel for flush or rows past the frame; result emission.
	assign pix  = (s_axis_tuser || in_row_q >= h_eff) ? 8'd0 : s_axis_tdata;
	assign emit = n_q >= lag;
	assign last = ({1'b0, out_row_q} == h_eff - 11'd1) &&
		({1'b0, out_col_q} == w_eff - 11'd1);

	// Configuration registers and frame position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= 2'd1;
			width_q   <= 11'd640;
			height_q  <= 11'd480;
			in_col_q  <= '0;
			in_row_q  <= '0;
			in_slot_q <= '0;
			n_q       <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cfg_hit) begin
			unique case (cfg_index)
				bmf_pkg::REG_RADIUS: radius_q <= cfg_data[1:0];
				bmf_pkg::REG_WIDTH:  width_q  <= cfg_data;
				default:             height_q <= cfg_data;
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			in_slot_q <= '0;
			n_q       <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (accept) begin
			if (emit && last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				in_slot_q <= '0;
				n_q       <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end else begin
				n_q <= n_q + NW'(1);
				if ({1'b0, in_col_q} + 11'd1 >= w_eff) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + 11'd1;
					in_slot_q <= (in_slot_q == SW'(SLOTS - 1)) ? '0 : in_slot_q + SW'(1);
				end else begin
					in_col_q <= in_col_q + 10'd1;
				end
				if (emit) begin
					if ({1'b0, out_col_q} + 11'd1 >= w_eff) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 10'd1;
					end else begin
						out_col_q <= out_col_q + 10'd1;
					end
				end
			end
		end
	end

	// Line banks, one per row slot.
	for (genvar j = 0; j < SLOTS; j++) begin : g_bank
		bmf_line_bank #(
			.DEPTH(MAX_LINE_WIDTH)
		) u_bank (
			.clk  (clk),
			.we   (accept && in_slot_q == SW'(j)),
			.re   (accept),
			.addr (AW'(in_col_q)),
			.wdata(pix),
			.rdata(rd[j])
		);
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pix;
			slot_s1 <= in_slot_q;
			row_s1  <= in_row_q;
			emit_s1 <= emit;
			last_s1 <= last;
			orow_s1 <= out_row_q;
			ocol_s1 <= out_col_q;
		end
	end

	// Column sum over the current row and up to 2r rows above it.
	always_comb begin
		int idx;
		colsum = bmf_pkg::COLSUM_W'(pix_s1);
		for (int k = 1; k < CELLS; k++) begin
			idx = (int'(slot_s1) >= k) ? int'(slot_s1) - k : int'(slot_s1) + SLOTS - k;
			if (k <= 2 * int'(r_eff) && k <= int'(row_s1)) begin
				colsum = colsum + bmf_pkg::COLSUM_W'(rd[SW'(idx)]);
			end
		end
	end

	// Chain of window cells; cell 0 holds the newest column.
	assign chain[0].colsum = colsum;
	assign chain[0].row    = row_s1;
	assign want_row        = {1'b0, orow_s2} + bmf_pkg::ROW_W'(r_eff);

	for (genvar j = 0; j < CELLS; j++) begin : g_cell
		bmf_cell u_cell (
			.clk     (clk),
			.shift   (adv && v_s1),
			.enable  (j <= 2 * int'(r_eff)),
			.want_row(want_row),
			.d       (chain[j]),
			.q       (chain[j+1]),
			.contrib (contrib[j])
		);
	end

	// Stage 2 control and payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			emit_s2 <= emit_s1;
			last_s2 <= last_s1;
			orow_s2 <= orow_s1;
			ocol_s2 <= ocol_s1;
		end
	end

	// Window sum across the cells.
	always_comb begin
		wsum = '0;
		for (int j = 0; j < CELLS; j++) begin
			wsum = wsum + bmf_pkg::WSUM_W'(contrib[j]);
		end
	end

	// Stage 3 control and payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			emit_s3 <= emit_s2;
			last_s3 <= last_s2;
			orow_s3 <= orow_s2;
			ocol_s3 <= ocol_s2;
			wsum_s3 <= wsum;
		end
	end

	// Divide by (2r+1)^2 through the reciprocal table.
	assign prod = (bmf_pkg::WSUM_W + bmf_pkg::RECIP_W)'(wsum_s3) *
		(bmf_pkg::WSUM_W + bmf_pkg::RECIP_W)'(bmf_pkg::RECIP[3'(r_eff)]);

	// Output register; items before the lag produce no result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s3 && emit_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3) begin
			mean_q <= prod[bmf_pkg::RECIP_SHIFT +: 8];
			orow_q <= orow_s3;
			ocol_q <= ocol_s3;
			last_q <= last_s3;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, ocol_q, orow_q, mean_q};
	assign m_axis_tlast  = last_q;

endmodule

// File: design/bmf_checker.sv
// Port-level checker for box_mean_filter_2d, bound to every instance of the top level.
// Depends only on the top level's ports.
module bmf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [1:0]  cfg_index,
	input logic [10:0] cfg_data,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// With an empty output register the block always takes an item.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output");

	// The padding bits above the output column stay zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:28] == 4'd0)
		else $error("nonzero padding in result");

	// A new result only appears after a pipeline advance.
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tready))
		else $error("result appeared without pipeline advance");

endmodule

bind box_mean_filter_2d bmf_checker u_bmf_checker (.*);

// File: verif/tb_box_mean_filter_2d.sv
// Self-checking testbench for box_mean_filter_2d: zero-padded box mean over raster frames.
// Depends on bmf_pkg and the block's RTL; it predicts every result on its own and compares.
`timescale 1ns / 100ps

module tb_box_mean_filter_2d;

	// One result as the block presents it.
	typedef struct packed {
		logic [7:0] mean;
		logic [9:0] row;
		logic [9:0] col;
		logic       last;
	} filt_res_t;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_ITEMS = 750;

	// Register index that selects no register.
	localparam logic [1:0] REG_SPARE = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [10:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // pixel_in
	logic        s_axis_tuser;   // flush
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // mean_value, out_row, out_col, zero fill
	logic        m_axis_tlast;   // frame_last

	// Predictor state: line store, input position and register copies.
	logic [7:0]  line_mem [8*1024];
	int          row_cnt;
	int          col_cnt;
	logic [1:0]  rad_reg;
	logic [10:0] width_reg;
	logic [10:0] height_reg;

	filt_res_t   pending_means[$];
	int          errors;
	int          items_sent;
	int          results_checked;
	int          frames_done;
	int          quiet_cycles;
	bit          no_idle;

	box_mean_filter_2d dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	// Clamp the width and height registers the way the block reads them.
	function automatic int clamp_dim(input logic [10:0] v);
		int d;
		d = v;
		if (d < 1) d = 1;
		if (d > bmf_pkg::FRAME_LIMIT) d = bmf_pkg::FRAME_LIMIT;
		return d;
	endfunction

	// Computes the window mean that one accepted item releases, if any.
	function automatic bit window_mean(input logic [7:0] pix_in, input logic fl,
			output filt_res_t res);
		int r, w, h, pix, n, lag, idx, orow, ocol, sum, d, y, x;
		r = rad_reg;
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		pix = fl ? 0 : pix_in;
		res = '0;
		if (row_cnt >= h) pix = 0;
		if (col_cnt < w) line_mem[(row_cnt % 8) * 1024 + col_cnt] = 8'(pix);
		n = row_cnt * w + col_cnt;
		lag = r * w + r;
		col_cnt++;
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt++;
		end
		if (n < lag) return 0;
		idx = n - lag;
		orow = idx / w;
		ocol = idx % w;
		if (orow >= h) begin
			row_cnt = 0;
			col_cnt = 0;
			return 0;
		end
		sum = 0;
		for (int dy = -r; dy <= r; dy++) begin
			y = orow + dy;
			if (y < 0 || y >= h) continue;
			for (int dx = -r; dx <= r; dx++) begin
				x = ocol + dx;
				if (x < 0 || x >= w) continue;
				sum += line_mem[(y % 8) * 1024 + x];
			end
		end
		d = 2 * r + 1;
		res.mean = 8'(sum / (d * d));
		res.row = 10'(orow);
		res.col = 10'(ocol);
		res.last = (idx == h * w - 1);
		if (res.last) begin
			row_cnt = 0;
			col_cnt = 0;
		end
		return 1;
	endfunction

	// Sends one item, with a random gap before it unless idling is off.
	task automatic send_pixel(input logic [7:0] pix, input logic fl);
		filt_res_t res;
		if (!no_idle && $urandom_range(0, 99) < 33) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pix;
		s_axis_tuser <= fl;
		@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk);
		items_sent++;
		if (window_mean(pix, fl, res)) pending_means.push_back(res);
	endtask

	// Holds the sender until every expected result has come, then lets the pipe settle.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_means.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes one register; the predictor restarts its frame as the block does.
	task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		unique case (idx)
			bmf_pkg::REG_RADIUS: rad_reg = val[1:0];
			bmf_pkg::REG_WIDTH:  width_reg = val;
			bmf_pkg::REG_HEIGHT: height_reg = val;
			default: ;
		endcase
		if (idx == bmf_pkg::REG_RADIUS || idx == bmf_pkg::REG_WIDTH ||
				idx == bmf_pkg::REG_HEIGHT) begin
			row_cnt = 0;
			col_cnt = 0;
		end
		@(posedge clk);
	endtask

	// Empties the pipe, then writes all three registers.
	task automatic set_frame(input logic [10:0] rad, input logic [10:0] w,
			input logic [10:0] h);
		wait_drained();
		write_reg(bmf_pkg::REG_RADIUS, rad);
		write_reg(bmf_pkg::REG_WIDTH, w);
		write_reg(bmf_pkg::REG_HEIGHT, h);
	endtask

	// Sends one whole frame and its drain items. Mode 0 random, 1 all 255, 2 all 0.
	task automatic run_frame(input int mode, input int flush_pct);
		int w, h, r;
		logic [7:0] pix;
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		r = rad_reg;
		for (int i = 0; i < w * h; i++) begin
			pix = (mode == 1) ? 8'hFF : (mode == 2) ? 8'h00 : 8'($urandom());
			send_pixel(pix, $urandom_range(0, 99) < flush_pct);
		end
		// Drain items: mostly flagged, some plain items beyond the frame with junk data.
		for (int i = 0; i < r * w + r; i++)
			send_pixel(8'($urandom()), $urandom_range(0, 3) != 0);
		frames_done++;
	endtask

	// Smallest and largest values, every radius, flush in a tiny frame.
	task automatic test_directed();
		set_frame(0, 1, 1);
		send_pixel(8'hFF, 1'b0);
		set_frame(3, 1, 1);
		send_pixel(8'hFF, 1'b1);
		for (int i = 0; i < 6; i++) send_pixel(8'hAA, 1'b0);
		set_frame(1, 3, 2);
		run_frame(1, 0);
		set_frame(2, 2, 2);
		run_frame(2, 0);
		wait_drained();
	endtask

	// Out-of-range sizes: zero taken as one, oversize saturated; the widest line.
	task automatic test_saturation();
		set_frame(11'h7FF, 11'd0, 11'd0);
		run_frame(1, 0);
		set_frame(11'h7FC, 11'h7FF, 11'd1);
		run_frame(1, 0);
		set_frame(11'd1, 11'd2, 11'h7FF);
		for (int i = 0; i < 20; i++) send_pixel(8'($urandom()), 1'b0);
		wait_drained();
	endtask

	// A frame cut short by a register write, and a write to the unused index.
	task automatic test_restart();
		set_frame(2, 5, 4);
		for (int i = 0; i < 13; i++) send_pixel(8'($urandom()), 1'b0);
		wait_drained();
		write_reg(REG_SPARE, 11'($urandom()));
		for (int i = 0; i < 4; i++) send_pixel(8'($urandom()), 1'b0);
		wait_drained();
		write_reg(bmf_pkg::REG_HEIGHT, 11'd3);
		run_frame(0, 10);
		wait_drained();
	endtask

	// Random small frames, with a quiet stretch and occasional mid-frame pauses.
	task automatic test_random_frames();
		int start;
		int cnt;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			no_idle = ((items_sent - start) > 250 && (items_sent - start) < 500);
			set_frame({9'($urandom()), 2'($urandom())}, 11'($urandom_range(1, 12)),
				11'($urandom_range(1, 8)));
			if ($urandom_range(0, 9) == 0) begin
				cnt = $urandom_range(1, 20);
				for (int i = 0; i < cnt; i++)
					send_pixel(8'($urandom()), 1'b0);
			end else begin
				run_frame($urandom_range(0, 9) == 0 ? 1 : 0, $urandom_range(0, 15));
			end
			if ($urandom_range(0, 3) == 0) begin
				send_pixel(8'($urandom()), 1'b0);
				wait_drained();
			end
			wait_drained();
		end
		no_idle = 1'b0;
	endtask

	// Receiver stalls at random except during the quiet stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 33);
		end
	end

	// Compares each result with the oldest expectation.
	always @(posedge clk) begin
		filt_res_t exp_res;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_means.size() == 0) begin
				$display("%0t: unexpected result tdata=%h tlast=%b", $time, m_axis_tdata,
					m_axis_tlast);
				errors++;
			end else begin
				exp_res = pending_means.pop_front();
				results_checked++;
				if (m_axis_tdata !== {4'b0, exp_res.col, exp_res.row, exp_res.mean} ||
						m_axis_tlast !== exp_res.last) begin
					$display({"%0t: expected mean=%0d row=%0d col=%0d last=%b, ",
						"got mean=%0d row=%0d col=%0d last=%b fill=%h"},
						$time, exp_res.mean, exp_res.row, exp_res.col, exp_res.last,
						m_axis_tdata[7:0], m_axis_tdata[17:8], m_axis_tdata[27:18],
						m_axis_tlast, m_axis_tdata[31:28]);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles where neither side moves an item.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				pending_means.size());
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		errors = 0;
		items_sent = 0;
		results_checked = 0;
		frames_done = 0;
		quiet_cycles = 0;
		no_idle = 1'b0;
		foreach (line_mem[i]) line_mem[i] = '0;
		row_cnt = 0;
		col_cnt = 0;
		rad_reg = 2'd1;
		width_reg = 11'd640;
		height_reg = 11'd480;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_saturation();
		test_restart();
		test_random_frames();

		wait_drained();
		$display("Covered %0d items, %0d results checked, %0d frames over all radii,",
			items_sent, results_checked, frames_done);
		$display("saturated sizes, restarts by register writes and flush inside frames.");
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
